// File: rtl/ttw_pkg.sv
// shared types and constants for the text terminal tile writer
package ttw_pkg;

  localparam int ROWS_DEF = 24;
  localparam int COLS_DEF = 32;

  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_SET   = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  localparam logic [7:0] CHAR_NL    = 8'd10;
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_LAST  = 8'd126;

  localparam logic [15:0] TILE_RESET = 16'h0020;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] char_code;
    logic [5:0] col;
    logic [4:0] row;
  } ttw_cmd_t;

  typedef struct packed {
    logic [15:0] tile_word;
    logic [5:0]  cursor_col;
    logic [4:0]  cursor_row;
  } ttw_rsp_t;

  // tile word from palette and byte, non-printable bytes drawn as a space
  function automatic logic [15:0] char_tile(input logic [3:0] pal, input logic [7:0] ch);
    logic [7:0] c;
    c = ((ch < CHAR_SPACE) || (ch > CHAR_LAST)) ? CHAR_SPACE : ch;
    return {pal, 4'h0, c};
  endfunction

endpackage

// File: rtl/ttw_tile_ram.sv
// tile store: one write port, one registered read port
module ttw_tile_ram #(
  parameter int DEPTH = 768,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [15:0]   rdata
);

  logic [15:0] mem [0:DEPTH-1];
  logic [15:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/ttw_addr_unit.sv
// maps a screen row and column to a store address through the scroll offset
module ttw_addr_unit #(
  parameter int ROWS = 24,
  parameter int RW   = 5,
  parameter int CW   = 5
) (
  input  logic [RW-1:0]    lrow,
  input  logic [CW-1:0]    lcol,
  input  logic [RW-1:0]    top,
  output logic [RW+CW-1:0] addr
);

  logic [RW:0]   sum;
  logic [RW-1:0] prow;

  always_comb begin
    sum = {1'b0, lrow} + {1'b0, top};
    if (sum >= (RW+1)'(ROWS)) begin
      sum = sum - (RW+1)'(ROWS);
    end
    prow = sum[RW-1:0];
  end

  assign addr = {prow, lcol};

endmodule

// File: rtl/text_terminal_tile_writer_core.sv
// text terminal tile writer: command sequencer, cursor and scroll offset
//
// A command (op, char_code, col, row) is transferred at a clock edge with start
// high and busy low. Exactly one result (tile_word, cursor_col, cursor_row) is
// shown for one cycle with out_strobe high; the receiver cannot stall it.
// cfg_we writes the 4-bit palette; the user is to write it only while the block is
// idle, which the block itself does not enforce.
// Steps from the transfer edge to the result cycle:
//   set cursor, put character without wrap: executed at once
//   read cell: registered store read, then the result
//   put character or newline with line feed, no scroll: line feed, then any character
//   line feed on the last row: the scroll is a row offset register, the new
//   bottom row is blanked one cell a cycle; clear: one store write a cycle
// busy is high from the transfer through the result cycle, so a new command is
// taken the cycle after the result at the earliest.
// After reset the store is swept to blank tiles 0x0020 one cell a cycle with
// busy high; configuration writes are taken meanwhile. Reset homes the cursor
// and sets the palette to 0.
module text_terminal_tile_writer_core #(
  parameter int ROWS = ttw_pkg::ROWS_DEF,
  parameter int COLS = ttw_pkg::COLS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  ttw_pkg::ttw_cmd_t in_cmd,
  output logic              out_strobe,
  output ttw_pkg::ttw_rsp_t out_rsp,
  input  logic              cfg_we,
  input  logic [3:0]        cfg_wdata
);

  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLS);
  localparam int CCW   = $clog2(COLS + 1);
  localparam int AW    = RW + CW;
  localparam int DEPTH = ROWS << CW;

  localparam logic [11:0] TILE_LOW = ttw_pkg::TILE_RESET[11:0];

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_EXEC   = 3'd2;
  localparam logic [2:0] S_SCROLL = 3'd3;
  localparam logic [2:0] S_CLEAR  = 3'd4;
  localparam logic [2:0] S_WRITE  = 3'd5;
  localparam logic [2:0] S_RDWAIT = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0]     state_r, state_nxt;
  logic [1:0]     op_r, op_nxt;
  logic [7:0]     ch_r, ch_nxt;
  logic [CW-1:0]  csat_r, csat_nxt;
  logic [RW-1:0]  rsat_r, rsat_nxt;
  logic           pend_r, pend_nxt;
  logic [CCW-1:0] cur_col_r, cur_col_nxt;
  logic [RW-1:0]  cur_row_r, cur_row_nxt;
  logic [RW-1:0]  top_r, top_nxt;
  logic [CW-1:0]  swp_col_r, swp_col_nxt;
  logic [RW-1:0]  swp_row_r, swp_row_nxt;
  logic [15:0]    tile_r, tile_nxt;
  logic [3:0]     pal_r;

  logic           ram_we, ram_re;
  logic [15:0]    ram_wdata, ram_rdata;
  logic [AW-1:0]  addr;
  logic [RW-1:0]  lrow;
  logic [CW-1:0]  lcol;
  logic [15:0]    blank;
  logic [15:0]    put_tile;
  logic           swp_row_end;
  logic           swp_grid_end;

  assign blank        = {pal_r, TILE_LOW};
  assign put_tile     = ttw_pkg::char_tile(pal_r, ch_r);
  assign swp_row_end  = (swp_col_r == CW'(COLS - 1));
  assign swp_grid_end = swp_row_end && (swp_row_r == RW'(ROWS - 1));

  ttw_addr_unit #(
    .ROWS (ROWS),
    .RW   (RW),
    .CW   (CW)
  ) u_addr (
    .lrow (lrow),
    .lcol (lcol),
    .top  (top_r),
    .addr (addr)
  );

  ttw_tile_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    ch_nxt      = ch_r;
    csat_nxt    = csat_r;
    rsat_nxt    = rsat_r;
    pend_nxt    = pend_r;
    cur_col_nxt = cur_col_r;
    cur_row_nxt = cur_row_r;
    top_nxt     = top_r;
    swp_col_nxt = swp_col_r;
    swp_row_nxt = swp_row_r;
    tile_nxt    = tile_r;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_wdata   = blank;
    lrow        = cur_row_r;
    lcol        = cur_col_r[CW-1:0];

    unique case (state_r) inside
      S_INIT, S_CLEAR: begin
        lrow      = swp_row_r;
        lcol      = swp_col_r;
        ram_we    = 1'b1;
        ram_wdata = (state_r == S_INIT) ? ttw_pkg::TILE_RESET : blank;
        if (swp_grid_end) begin
          state_nxt = (state_r == S_INIT) ? S_IDLE : S_DONE;
        end else if (swp_row_end) begin
          swp_col_nxt = '0;
          swp_row_nxt = swp_row_r + RW'(1);
        end else begin
          swp_col_nxt = swp_col_r + CW'(1);
        end
      end
      S_IDLE: begin
        if (start) begin
          op_nxt    = in_cmd.op;
          ch_nxt    = in_cmd.char_code;
          csat_nxt  = (32'(in_cmd.col) > 32'(COLS - 1)) ? CW'(COLS - 1) : CW'(in_cmd.col);
          rsat_nxt  = (32'(in_cmd.row) > 32'(ROWS - 1)) ? RW'(ROWS - 1) : RW'(in_cmd.row);
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        tile_nxt = '0;
        case (op_r)
          ttw_pkg::OP_PUT: begin
            if ((ch_r == ttw_pkg::CHAR_NL) || (cur_col_r == CCW'(COLS))) begin
              // line feed, then the character if it is not a newline
              cur_col_nxt = '0;
              pend_nxt    = (ch_r != ttw_pkg::CHAR_NL);
              if (cur_row_r != RW'(ROWS - 1)) begin
                cur_row_nxt = cur_row_r + RW'(1);
                state_nxt   = pend_nxt ? S_WRITE : S_DONE;
              end else begin
                // old top row becomes the new bottom row
                top_nxt     = (top_r == RW'(ROWS - 1)) ? '0 : top_r + RW'(1);
                swp_col_nxt = '0;
                state_nxt   = S_SCROLL;
              end
            end else begin
              ram_we      = 1'b1;
              ram_wdata   = put_tile;
              cur_col_nxt = cur_col_r + CCW'(1);
              state_nxt   = S_DONE;
            end
          end
          ttw_pkg::OP_CLEAR: begin
            cur_col_nxt = '0;
            cur_row_nxt = '0;
            top_nxt     = '0;
            swp_col_nxt = '0;
            swp_row_nxt = '0;
            state_nxt   = S_CLEAR;
          end
          ttw_pkg::OP_SET: begin
            cur_col_nxt = CCW'(csat_r);
            cur_row_nxt = rsat_r;
            state_nxt   = S_DONE;
          end
          default: begin
            lrow      = rsat_r;
            lcol      = csat_r;
            ram_re    = 1'b1;
            state_nxt = S_RDWAIT;
          end
        endcase
      end
      S_SCROLL: begin
        lrow   = RW'(ROWS - 1);
        lcol   = swp_col_r;
        ram_we = 1'b1;
        if (swp_row_end) begin
          state_nxt = pend_r ? S_WRITE : S_DONE;
        end else begin
          swp_col_nxt = swp_col_r + CW'(1);
        end
      end
      S_WRITE: begin
        ram_we      = 1'b1;
        ram_wdata   = put_tile;
        cur_col_nxt = cur_col_r + CCW'(1);
        state_nxt   = S_DONE;
      end
      S_RDWAIT: begin
        tile_nxt  = ram_rdata;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_INIT;
      pend_r    <= 1'b0;
      cur_col_r <= '0;
      cur_row_r <= '0;
      top_r     <= '0;
      swp_col_r <= '0;
      swp_row_r <= '0;
      pal_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      pend_r    <= pend_nxt;
      cur_col_r <= cur_col_nxt;
      cur_row_r <= cur_row_nxt;
      top_r     <= top_nxt;
      swp_col_r <= swp_col_nxt;
      swp_row_r <= swp_row_nxt;
      if (cfg_we) begin
        pal_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    ch_r   <= ch_nxt;
    csat_r <= csat_nxt;
    rsat_r <= rsat_nxt;
    tile_r <= tile_nxt;
  end

  assign busy                = (state_r != S_IDLE);
  assign out_strobe          = (state_r == S_DONE);
  assign out_rsp.tile_word   = tile_r;
  assign out_rsp.cursor_col  = 6'(cur_col_r);
  assign out_rsp.cursor_row  = 5'(cur_row_r);

endmodule

// File: dv/ttw_screen_checker.sv
// checker for the text terminal tile writer: screen and cursor predictor plus result compare
`timescale 1ns / 1ps

module ttw_screen_checker #(
  parameter int ROWS = ttw_pkg::ROWS_DEF,
  parameter int COLS = ttw_pkg::COLS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  ttw_pkg::ttw_cmd_t in_cmd,
  input  logic              out_strobe,
  input  ttw_pkg::ttw_rsp_t out_rsp,
  input  logic              cfg_we,
  input  logic [3:0]        cfg_wdata,
  output int                mismatch_total,
  output int                outstanding
);

  logic [15:0]       screen [0:ROWS*COLS-1];
  logic [5:0]        cur_col;
  logic [4:0]        cur_row;
  logic [3:0]        palette;
  ttw_pkg::ttw_rsp_t console_rsp_q [$];

  function automatic logic [15:0] blank_word();
    return {palette, 4'h0, ttw_pkg::CHAR_SPACE};
  endfunction

  // line feed, scrolling the whole screen up when already on the bottom row
  function automatic void line_feed();
    int i;
    cur_col = '0;
    if (cur_row < ROWS - 1) begin
      cur_row = cur_row + 5'd1;
    end else begin
      for (i = 0; i < (ROWS - 1) * COLS; i++) screen[i] = screen[i + COLS];
      for (i = (ROWS - 1) * COLS; i < ROWS * COLS; i++) screen[i] = blank_word();
    end
  endfunction

  function automatic ttw_pkg::ttw_rsp_t console_step(input ttw_pkg::ttw_cmd_t cmd);
    ttw_pkg::ttw_rsp_t rsp;
    logic [7:0]        glyph;
    int                c;
    int                r;
    int                i;
    rsp = '0;
    c = (cmd.col > COLS - 1) ? COLS - 1 : int'(cmd.col);
    r = (cmd.row > ROWS - 1) ? ROWS - 1 : int'(cmd.row);
    case (cmd.op)
      ttw_pkg::OP_PUT: begin
        if (cmd.char_code == ttw_pkg::CHAR_NL) begin
          line_feed();
        end else begin
          // pending wrap is resolved only when the next byte arrives
          if (cur_col >= COLS) line_feed();
          glyph = (cmd.char_code < ttw_pkg::CHAR_SPACE ||
                   cmd.char_code > ttw_pkg::CHAR_LAST) ?
                  ttw_pkg::CHAR_SPACE : cmd.char_code;
          screen[int'(cur_row) * COLS + int'(cur_col)] = {palette, 4'h0, glyph};
          cur_col = cur_col + 6'd1;
        end
      end
      ttw_pkg::OP_CLEAR: begin
        for (i = 0; i < ROWS * COLS; i++) screen[i] = blank_word();
        cur_col = '0;
        cur_row = '0;
      end
      ttw_pkg::OP_SET: begin
        cur_col = c[5:0];
        cur_row = r[4:0];
      end
      default: begin
        rsp.tile_word = screen[r * COLS + c];
      end
    endcase
    rsp.cursor_col = cur_col;
    rsp.cursor_row = cur_row;
    return rsp;
  endfunction

  always @(posedge clk) begin
    ttw_pkg::ttw_rsp_t want;
    int                i;
    if (!rst_n) begin
      for (i = 0; i < ROWS * COLS; i++) screen[i] = ttw_pkg::TILE_RESET;
      cur_col = '0;
      cur_row = '0;
      palette = '0;
      console_rsp_q.delete();
      mismatch_total = 0;
      outstanding <= 0;
    end else begin
      if (cfg_we) palette = cfg_wdata;
      if (out_strobe) begin
        if (console_rsp_q.size() == 0) begin
          if (mismatch_total < 10)
            $display("%0t: result with nothing pending: tile %h col %0d row %0d",
                     $realtime, out_rsp.tile_word, out_rsp.cursor_col, out_rsp.cursor_row);
          mismatch_total++;
        end else begin
          want = console_rsp_q.pop_front();
          if (out_rsp.tile_word !== want.tile_word ||
              out_rsp.cursor_col !== want.cursor_col ||
              out_rsp.cursor_row !== want.cursor_row) begin
            if (mismatch_total < 10)
              $display("%0t: mismatch tile %h/%h col %0d/%0d row %0d/%0d (expected/actual)",
                       $realtime, want.tile_word, out_rsp.tile_word,
                       want.cursor_col, out_rsp.cursor_col,
                       want.cursor_row, out_rsp.cursor_row);
            mismatch_total++;
          end
        end
      end
      if (start && !busy) console_rsp_q.push_back(console_step(in_cmd));
      outstanding <= console_rsp_q.size();
    end
  end

endmodule

// File: dv/tb_top.sv
// testbench top for the text terminal tile writer: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_top;

  localparam int QUIET_LIMIT = 4000;
  localparam int PHASE_ITEMS = 190;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  ttw_pkg::ttw_cmd_t in_cmd;
  logic              out_strobe;
  ttw_pkg::ttw_rsp_t out_rsp;
  logic              cfg_we;
  logic [3:0]        cfg_wdata;
  int                mismatch_total;
  int                outstanding;
  int                quiet_cycles;
  bit                idle_en;

  text_terminal_tile_writer_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_cmd    (in_cmd),
    .out_strobe(out_strobe),
    .out_rsp   (out_rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  ttw_screen_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_cmd        (in_cmd),
    .out_strobe    (out_strobe),
    .out_rsp       (out_rsp),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .mismatch_total(mismatch_total),
    .outstanding   (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ends the run when nothing has been transferred for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_cmd(input logic [1:0] op, input logic [7:0] ch,
                          input logic [5:0] c, input logic [4:0] r);
    ttw_pkg::ttw_cmd_t cmd;
    cmd.op        = op;
    cmd.char_code = ch;
    cmd.col       = c;
    cmd.row       = r;
    if (idle_en && $urandom_range(99) < 34) begin
      start <= 1'b0;
      if ($urandom_range(3) == 0) repeat ($urandom_range(4, 40)) @(posedge clk);
      else repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    start  <= 1'b1;
    in_cmd <= cmd;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_palette(input logic [3:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic send_random();
    int         sel;
    int         k;
    logic [7:0] ch;
    logic [5:0] c;
    logic [4:0] r;
    sel = $urandom_range(99);
    ch  = 8'($urandom_range(255));
    c   = 6'($urandom_range(63));
    r   = 5'($urandom_range(31));
    if (sel < 2) begin
      send_cmd(ttw_pkg::OP_CLEAR, ch, c, r);
    end else if (sel < 20) begin
      if ($urandom_range(4) != 0) begin
        c = 6'($urandom_range(ttw_pkg::COLS_DEF - 1));
        r = 5'($urandom_range(ttw_pkg::ROWS_DEF - 1));
      end
      send_cmd(ttw_pkg::OP_READ, ch, c, r);
    end else if (sel < 32) begin
      k = $urandom_range(9);
      // lean toward the right edge and the bottom rows to reach wrap and scroll
      if (k < 4) begin
        c = 6'($urandom_range(ttw_pkg::COLS_DEF - 1, ttw_pkg::COLS_DEF - 4));
        r = 5'($urandom_range(ttw_pkg::ROWS_DEF - 1, ttw_pkg::ROWS_DEF - 3));
      end else if (k < 8) begin
        c = 6'($urandom_range(ttw_pkg::COLS_DEF - 1));
        r = 5'($urandom_range(ttw_pkg::ROWS_DEF - 1));
      end
      send_cmd(ttw_pkg::OP_SET, ch, c, r);
    end else begin
      k = $urandom_range(9);
      if (k == 0) ch = ttw_pkg::CHAR_NL;
      else if (k > 1) ch = 8'($urandom_range(ttw_pkg::CHAR_LAST, ttw_pkg::CHAR_SPACE));
      send_cmd(ttw_pkg::OP_PUT, ch, c, r);
    end
  endtask

  initial begin
    logic [3:0] palettes [5];
    int         p;
    int         n;
    palettes = '{4'd3, 4'd0, 4'd15, 4'd9, 4'd0};
    palettes[3] = 4'($urandom_range(15));
    idle_en   = 1'b1;
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_cmd    <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset contents before any palette is set
    send_cmd(ttw_pkg::OP_READ, 8'h00, 6'd0, 5'd0);
    send_cmd(ttw_pkg::OP_READ, 8'hff, 6'd63, 5'd31);
    drain();
    write_palette(4'd15);

    send_cmd(ttw_pkg::OP_PUT, 8'd65, 6'd0, 5'd0);
    send_cmd(ttw_pkg::OP_PUT, 8'd0, 6'd63, 5'd31);
    send_cmd(ttw_pkg::OP_PUT, 8'd126, 6'd0, 5'd0);
    send_cmd(ttw_pkg::OP_PUT, 8'd127, 6'd0, 5'd0);
    send_cmd(ttw_pkg::OP_PUT, 8'd255, 6'd0, 5'd0);
    send_cmd(ttw_pkg::OP_PUT, 8'd31, 6'd0, 5'd0);
    send_cmd(ttw_pkg::OP_PUT, ttw_pkg::CHAR_NL, 6'd0, 5'd0);
    send_cmd(ttw_pkg::OP_READ, 8'd0, 6'd1, 5'd0);
    send_cmd(ttw_pkg::OP_READ, 8'd0, 6'd4, 5'd0);
    // wrap pending then newline, away from the bottom
    send_cmd(ttw_pkg::OP_SET, 8'd0, 6'd31, 5'd5);
    send_cmd(ttw_pkg::OP_PUT, 8'd90, 6'd0, 5'd0);
    send_cmd(ttw_pkg::OP_PUT, ttw_pkg::CHAR_NL, 6'd0, 5'd0);
    // saturated cursor, wrap on the bottom row scrolls
    send_cmd(ttw_pkg::OP_SET, 8'd0, 6'd63, 5'd31);
    send_cmd(ttw_pkg::OP_PUT, 8'd120, 6'd0, 5'd0);
    send_cmd(ttw_pkg::OP_PUT, 8'd121, 6'd0, 5'd0);
    send_cmd(ttw_pkg::OP_READ, 8'd0, 6'd31, 5'd22);
    send_cmd(ttw_pkg::OP_READ, 8'd0, 6'd32, 5'd24);
    send_cmd(ttw_pkg::OP_PUT, ttw_pkg::CHAR_NL, 6'd0, 5'd0);
    send_cmd(ttw_pkg::OP_READ, 8'd0, 6'd0, 5'd22);
    send_cmd(ttw_pkg::OP_READ, 8'd0, 6'd31, 5'd4);
    send_cmd(ttw_pkg::OP_CLEAR, 8'hff, 6'd63, 5'd31);
    send_cmd(ttw_pkg::OP_READ, 8'd0, 6'd0, 5'd0);
    send_cmd(ttw_pkg::OP_SET, 8'd0, 6'd32, 5'd24);
    send_cmd(ttw_pkg::OP_PUT, 8'd33, 6'd0, 5'd0);

    for (p = 0; p < 5; p++) begin
      drain();
      write_palette(palettes[p]);
      idle_en = (p != 2);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        send_random();
        // sender holds off until the block has caught up
        if (n == PHASE_ITEMS / 2 && p == 1) drain();
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (mismatch_total == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
